[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIPCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is asserted.
`define PIPCT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

[rtl/pipct_pkg.sv]
`default_nettype none
package pipct_pkg;

  localparam int FIELD_W         = 32;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int TOL_WIDTH       = 32;
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 32'd66;
  localparam int IN_TDATA_W      = 6 * FIELD_W;
  localparam int OUT_TDATA_W     = 8;

  typedef struct packed {
    logic last;
    logic in_box;
    logic strad;
    logic vtx;
    logic vcnt;
    logic b_lt_a;
  } flags_t;

endpackage
`default_nettype wire

[rtl/point_in_polygon_crossing_test_core.sv]
`default_nettype none
// Channel  | Direction | Beat contents
// in_      | slave     | tdata: query_x, query_y, edge_ax, edge_ay, edge_bx, edge_by; tlast: final_edge
// out_     | master    | tdata: inside_res, on_boundary, zero fill to 8 bits
// cfg_     | write     | wr_data: on_line_tolerance
//
// One edge beat is accepted in every cycle while the result register is free or being taken.
// A result passes through the input register, which takes its final edge beat, then the
// product register, and then the result register behind the cross-product compare.
// A stalled result holds the whole pipeline, so while it waits in_tready follows out_tready.
// Reset is synchronous: the tolerance returns to 66 and the parity and hit bits clear.
module point_in_polygon_crossing_test_core #(
  parameter int COORD_WIDTH = pipct_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // query_x, query_y, edge_ax, edge_ay, edge_bx, edge_by, 32 bits each from bit 0.
  input  wire logic [pipct_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic                               in_tlast,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // inside_res at bit 0, on_boundary at bit 1, zeros above.
  output logic [pipct_pkg::OUT_TDATA_W-1:0]       out_tdata,
  input  wire logic                               cfg_wr_en,
  input  wire logic [pipct_pkg::TOL_WIDTH-1:0]    cfg_wr_data
);
  import pipct_pkg::*;

  logic en;
  logic s1_valid_r;
  logic signed [COORD_WIDTH-1:0] px_r, py_r, ax_r, ay_r, bx_r, by_r;
  logic last_r;
  logic s2_valid;
  logic signed [2*COORD_WIDTH+1:0] p1, p2;
  flags_t flags;
  logic out_valid, in_poly, bound;

  assign en        = !out_valid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r   <= in_tdata[0*FIELD_W +: COORD_WIDTH];
      py_r   <= in_tdata[1*FIELD_W +: COORD_WIDTH];
      ax_r   <= in_tdata[2*FIELD_W +: COORD_WIDTH];
      ay_r   <= in_tdata[3*FIELD_W +: COORD_WIDTH];
      bx_r   <= in_tdata[4*FIELD_W +: COORD_WIDTH];
      by_r   <= in_tdata[5*FIELD_W +: COORD_WIDTH];
      last_r <= in_tlast;
    end
  end

  pipct_prod #(.COORD_WIDTH(COORD_WIDTH)) u_prod (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .s1_valid   (s1_valid_r),
    .px         (px_r),
    .py         (py_r),
    .ax         (ax_r),
    .ay         (ay_r),
    .bx         (bx_r),
    .by         (by_r),
    .last       (last_r),
    .s2_valid_r (s2_valid),
    .p1_r       (p1),
    .p2_r       (p2),
    .flags_r    (flags)
  );

  pipct_acc #(.COORD_WIDTH(COORD_WIDTH)) u_acc (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .s2_valid    (s2_valid),
    .p1          (p1),
    .p2          (p2),
    .flags       (flags),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tready  (out_tready),
    .out_valid_r (out_valid),
    .inside_r    (in_poly),
    .bound_r     (bound)
  );

  assign out_tvalid = out_valid;
  assign out_tdata  = {{(OUT_TDATA_W-2){1'b0}}, bound, in_poly};

endmodule
`default_nettype wire

[rtl/pipct_prod.sv]
`default_nettype none
module pipct_prod #(
  parameter int COORD_WIDTH = pipct_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire logic                           s1_valid,
  input  wire logic signed [COORD_WIDTH-1:0]  px,
  input  wire logic signed [COORD_WIDTH-1:0]  py,
  input  wire logic signed [COORD_WIDTH-1:0]  ax,
  input  wire logic signed [COORD_WIDTH-1:0]  ay,
  input  wire logic signed [COORD_WIDTH-1:0]  bx,
  input  wire logic signed [COORD_WIDTH-1:0]  by,
  input  wire logic                           last,
  output logic                                s2_valid_r,
  output logic signed [2*COORD_WIDTH+1:0]     p1_r,
  output logic signed [2*COORD_WIDTH+1:0]     p2_r,
  output pipct_pkg::flags_t                   flags_r
);
  import pipct_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * COORD_WIDTH + 2;

  logic signed [DW-1:0] dax, day, dbx, dby;
  logic signed [PW-1:0] p1_nxt, p2_nxt;
  logic signed [COORD_WIDTH-1:0] minx, maxx, miny, maxy;
  flags_t flags_nxt;

  assign dax = DW'(ax) - DW'(px);
  assign day = DW'(ay) - DW'(py);
  assign dbx = DW'(bx) - DW'(px);
  assign dby = DW'(by) - DW'(py);

  assign p1_nxt = PW'(dax) * PW'(dby);
  assign p2_nxt = PW'(day) * PW'(dbx);

  always_comb begin
    minx = (ax < bx) ? ax : bx;
    maxx = (ax < bx) ? bx : ax;
    miny = (ay < by) ? ay : by;
    maxy = (ay < by) ? by : ay;
    flags_nxt.last   = last;
    flags_nxt.in_box = (px >= minx) && (px <= maxx) && (py >= miny) && (py <= maxy);
    flags_nxt.strad  = (ay != by) && (py >= miny) && (py <= maxy);
    flags_nxt.vtx    = (ay == py) || (by == py);
    if (ay == py) begin
      flags_nxt.vcnt = (by > py) && (ax >= px);
    end else begin
      flags_nxt.vcnt = (ay > py) && (bx >= px);
    end
    flags_nxt.b_lt_a = by < ay;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r    <= p1_nxt;
      p2_r    <= p2_nxt;
      flags_r <= flags_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/pipct_acc.sv]
`default_nettype none
module pipct_acc #(
  parameter int COORD_WIDTH = pipct_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  en,
  input  wire logic                                  s2_valid,
  input  wire logic signed [2*COORD_WIDTH+1:0]       p1,
  input  wire logic signed [2*COORD_WIDTH+1:0]       p2,
  input  wire pipct_pkg::flags_t                     flags,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [pipct_pkg::TOL_WIDTH-1:0]       cfg_wr_data,
  input  wire logic                                  out_tready,
  output logic                                       out_valid_r,
  output logic                                       inside_r,
  output logic                                       bound_r
);
  import pipct_pkg::*;

  localparam int XW = 2 * COORD_WIDTH + 3;
  localparam int TW = XW + TOL_WIDTH;

  logic [TOL_WIDTH-1:0] tol_r;
  logic parity_r, parity_nxt;
  logic hit_r, hit_nxt;
  logic signed [XW-1:0] cross_v;
  logic signed [TW-1:0] cross_e, tol_e, ntol_e;
  logic neg, zero, near, count, toggle;
  logic out_valid_nxt;

  assign cross_v = XW'(p1) - XW'(p2);
  assign neg     = cross_v[XW-1];
  assign zero    = (cross_v == '0);
  assign cross_e = TW'(cross_v);
  assign tol_e   = signed'({{XW{1'b0}}, tol_r});
  assign ntol_e  = -tol_e;
  assign near    = (cross_e <= tol_e) && (cross_e >= ntol_e);
  assign count   = flags.vtx ? flags.vcnt : (zero || (neg == flags.b_lt_a));
  assign toggle  = flags.strad && count;

  always_comb begin
    parity_nxt    = parity_r ^ toggle;
    hit_nxt       = hit_r | (near && flags.in_box);
    out_valid_nxt = out_valid_r && !out_tready;
    if (s2_valid && flags.last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r       <= TOL_RESET;
      parity_r    <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tol_r <= cfg_wr_data;
      end
      if (en) begin
        out_valid_r <= out_valid_nxt;
        if (s2_valid) begin
          if (flags.last) begin
            parity_r <= 1'b0;
            hit_r    <= 1'b0;
          end else begin
            parity_r <= parity_nxt;
            hit_r    <= hit_nxt;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && s2_valid && flags.last) begin
      inside_r <= parity_nxt | hit_nxt;
      bound_r  <= hit_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/pipct_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module pipct_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [pipct_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import pipct_pkg::*;

  `PIPCT_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `PIPCT_ASSERT_IMP(a_bound_inside, clk, rst_n, out_tvalid && out_tdata[1], out_tdata[0])
  `PIPCT_ASSERT_IMP(a_fill_zero, clk, rst_n, out_tvalid, out_tdata[OUT_TDATA_W-1:2] == '0)
  `PIPCT_ASSERT_IMP(a_ready_free, clk, rst_n, !out_tvalid || out_tready, in_tready)

endmodule

bind point_in_polygon_crossing_test_core pipct_checker u_pipct_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
